@@ rtl/json_string_unescape_utf8_assert.svh @@
// Assertion macros shared by the decoder RTL files.
`ifndef JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH

// Plain property, checked outside reset.
`define JSU_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Same-cycle implication, checked outside reset.
`define JSU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/jsu_pkg.sv @@
// Shared types and codes for the JSON string unescape decoder.
package jsu_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [3:0] ERR_LF        = 4'd0;
  localparam logic [3:0] ERR_CR        = 4'd1;
  localparam logic [3:0] ERR_TAB       = 4'd2;
  localparam logic [3:0] ERR_CTRL      = 4'd3;
  localparam logic [3:0] ERR_BAD_ESC   = 4'd4;
  localparam logic [3:0] ERR_BAD_HEX   = 4'd5;
  localparam logic [3:0] ERR_LONE_LOW  = 4'd6;
  localparam logic [3:0] ERR_BAD_PAIR  = 4'd7;
  localparam logic [3:0] ERR_LONE_HIGH = 4'd8;

  // One queued burst: up to four results; cnt is the number of results minus one.
  typedef struct packed {
    logic [1:0]      cnt;
    logic [3:0][7:0] data;
    logic [1:0]      kind;
    logic [3:0]      code;
  } entry_t;

endpackage

@@ rtl/jsu_front.sv @@
// Front end: accepts input words, runs the escape decoder and builds result bursts.
module jsu_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  input  logic            restart,
  input  logic            full,
  output logic            push,
  output jsu_pkg::entry_t push_entry
);
  import jsu_pkg::*;

  localparam logic [1:0] PH_TEXT = 2'd0;
  localparam logic [1:0] PH_ESC  = 2'd1;
  localparam logic [1:0] PH_HEX  = 2'd2;
  localparam logic [1:0] PH_IDLE = 2'd3;

  logic [1:0]  phase, phase_next, ph;
  logic [1:0]  hex_count, hex_count_next, hc;
  logic [15:0] code_acc, code_acc_next, acc;
  logic [9:0]  high_half, high_half_next, hh;
  logic        high_pending, high_pending_next, hp;
  logic        accept;
  logic        emit;
  entry_t      ent;
  logic [4:0]  hex_d;
  logic [8:0]  esc_v;
  logic [15:0] cp;
  logic [20:0] full_cp;

  // {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) r = {1'b1, 4'(b - 8'h30)};
    else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
    else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
    return r;
  endfunction

  function automatic logic [8:0] esc_byte(input logic [7:0] b);
    logic [8:0] r;
    case (b)
      8'h22:   r = {1'b1, 8'h22};
      8'h5C:   r = {1'b1, 8'h5C};
      8'h2F:   r = {1'b1, 8'h2F};
      8'h62:   r = {1'b1, 8'h08};
      8'h66:   r = {1'b1, 8'h0C};
      8'h6E:   r = {1'b1, 8'h0A};
      8'h72:   r = {1'b1, 8'h0D};
      8'h74:   r = {1'b1, 8'h09};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  // Restart clears the state before this word is decoded.
  assign ph  = restart ? PH_TEXT : phase;
  assign hc  = restart ? 2'd0    : hex_count;
  assign acc = restart ? 16'd0   : code_acc;
  assign hh  = restart ? 10'd0   : high_half;
  assign hp  = restart ? 1'b0    : high_pending;

  assign hex_d   = hex_digit(in_byte);
  assign esc_v   = esc_byte(in_byte);
  assign cp      = {acc[11:0], hex_d[3:0]};
  assign full_cp = 21'h10000 + {1'b0, hh, cp[9:0]};

  always_comb begin
    phase_next        = ph;
    hex_count_next    = hc;
    code_acc_next     = acc;
    high_half_next    = hh;
    high_pending_next = hp;
    emit              = 1'b0;
    ent               = '0;
    ent.kind          = KIND_DATA;
    if (ph == PH_IDLE) begin
      emit = 1'b0;
    end else if (in_byte < 8'h20) begin
      emit       = 1'b1;
      ent.kind   = KIND_ERR;
      phase_next = PH_IDLE;
      case (in_byte)
        8'h0A:   ent.code = ERR_LF;
        8'h0D:   ent.code = ERR_CR;
        8'h09:   ent.code = ERR_TAB;
        default: ent.code = ERR_CTRL;
      endcase
    end else begin
      case (ph)
        PH_TEXT: begin
          if (in_byte == 8'h5C) begin
            phase_next = PH_ESC;
          end else begin
            emit = 1'b1;
            if (hp) begin
              ent.kind   = KIND_ERR;
              ent.code   = ERR_LONE_HIGH;
              phase_next = PH_IDLE;
            end else if (in_byte == 8'h22) begin
              ent.kind   = KIND_END;
              phase_next = PH_IDLE;
            end else begin
              ent.data[0] = in_byte;
            end
          end
        end
        PH_ESC: begin
          if (in_byte == 8'h75) begin
            phase_next     = PH_HEX;
            hex_count_next = 2'd0;
            code_acc_next  = 16'd0;
          end else begin
            emit = 1'b1;
            if (!esc_v[8]) begin
              ent.kind   = KIND_ERR;
              ent.code   = ERR_BAD_ESC;
              phase_next = PH_IDLE;
            end else if (hp) begin
              ent.kind   = KIND_ERR;
              ent.code   = ERR_LONE_HIGH;
              phase_next = PH_IDLE;
            end else begin
              ent.data[0] = esc_v[7:0];
              phase_next  = PH_TEXT;
            end
          end
        end
        PH_HEX: begin
          if (!hex_d[4]) begin
            emit       = 1'b1;
            ent.kind   = KIND_ERR;
            ent.code   = ERR_BAD_HEX;
            phase_next = PH_IDLE;
          end else if (hc != 2'd3) begin
            code_acc_next  = cp;
            hex_count_next = hc + 2'd1;
          end else begin
            code_acc_next  = cp;
            hex_count_next = 2'd0;
            phase_next     = PH_TEXT;
            if (!hp) begin
              if (cp >= 16'hD800 && cp <= 16'hDBFF) begin
                high_half_next    = cp[9:0];
                high_pending_next = 1'b1;
              end else if (cp >= 16'hDC00 && cp <= 16'hDFFF) begin
                emit       = 1'b1;
                ent.kind   = KIND_ERR;
                ent.code   = ERR_LONE_LOW;
                phase_next = PH_IDLE;
              end else if (cp <= 16'h007F) begin
                emit        = 1'b1;
                ent.data[0] = cp[7:0];
              end else if (cp <= 16'h07FF) begin
                emit        = 1'b1;
                ent.cnt     = 2'd1;
                ent.data[0] = {3'b110, cp[10:6]};
                ent.data[1] = {2'b10, cp[5:0]};
              end else begin
                emit        = 1'b1;
                ent.cnt     = 2'd2;
                ent.data[0] = {4'b1110, cp[15:12]};
                ent.data[1] = {2'b10, cp[11:6]};
                ent.data[2] = {2'b10, cp[5:0]};
              end
            end else if (cp < 16'hDC00 || cp > 16'hDFFF) begin
              emit       = 1'b1;
              ent.kind   = KIND_ERR;
              ent.code   = ERR_BAD_PAIR;
              phase_next = PH_IDLE;
            end else begin
              emit              = 1'b1;
              ent.cnt           = 2'd3;
              ent.data[0]       = {5'b11110, full_cp[20:18]};
              ent.data[1]       = {2'b10, full_cp[17:12]};
              ent.data[2]       = {2'b10, full_cp[11:6]};
              ent.data[3]       = {2'b10, full_cp[5:0]};
              high_half_next    = 10'd0;
              high_pending_next = 1'b0;
            end
          end
        end
        default: emit = 1'b0;
      endcase
    end
  end

  assign push       = accept && emit;
  assign push_entry = ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_TEXT;
      hex_count    <= 2'd0;
      code_acc     <= 16'd0;
      high_half    <= 10'd0;
      high_pending <= 1'b0;
    end else if (accept) begin
      phase        <= phase_next;
      hex_count    <= hex_count_next;
      code_acc     <= code_acc_next;
      high_half    <= high_half_next;
      high_pending <= high_pending_next;
    end
  end

`include "json_string_unescape_utf8_assert.svh"

  `JSU_ASSERT(a_fault_goes_idle, (push && push_entry.kind != KIND_DATA) |=> (phase == PH_IDLE), "end or error did not leave the decoder idle")

endmodule

@@ rtl/jsu_fifo.sv @@
// Short burst queue between the decoder front end and the result sequencer.
module jsu_fifo #(
  parameter int unsigned Depth = jsu_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  jsu_pkg::entry_t wr_data,
  output logic            full,
  input  logic            pop,
  output jsu_pkg::entry_t rd_data,
  output logic            empty
);
  import jsu_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t          mem [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  assign full    = (count == CntW'(Depth));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      if (pop)  rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      if (push && !pop)      count <= count + CntW'(1);
      else if (pop && !push) count <= count - CntW'(1);
    end
  end

`include "json_string_unescape_utf8_assert.svh"

  `JSU_ASSERT_IMP(a_no_push_full, push, !full, "burst pushed into a full queue")
  `JSU_ASSERT_IMP(a_no_pop_empty, pop, !empty, "burst popped from an empty queue")
  `JSU_ASSERT(a_count_bound, count <= CntW'(Depth), "queue count beyond depth")

endmodule

@@ rtl/jsu_back.sv @@
// Back end: unpacks queued bursts into single result words behind an output register.
module jsu_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            empty,
  input  jsu_pkg::entry_t rd_data,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic [1:0]      kind,
  output logic [3:0]      error_code,
  output logic            last
);
  import jsu_pkg::*;

  entry_t     cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       load;
  logic       fin;

  // Move one result into the output register whenever it is free or being taken.
  assign load = cur_valid && (!out_valid || out_ready);
  assign fin  = load && (idx == cur.cnt);
  assign pop  = !empty && (!cur_valid || fin);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
        idx       <= 2'd0;
      end else if (fin) begin
        cur_valid <= 1'b0;
      end else if (load) begin
        idx <= idx + 2'd1;
      end
      if (load)           out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= rd_data;
    if (load) begin
      out_byte   <= cur.data[idx];
      kind       <= cur.kind;
      error_code <= cur.code;
      last       <= (idx == cur.cnt);
    end
  end

`include "json_string_unescape_utf8_assert.svh"

  `JSU_ASSERT_IMP(a_end_is_last, out_valid && kind != KIND_DATA, last, "end or error word not marked last")

endmodule

@@ rtl/json_string_unescape_utf8.sv @@
// Top level of the JSON string body decoder with UTF-8 output.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------------------
//  input   | in        | in_valid / in_ready   | in_byte, restart
//  output  | out       | out_valid / out_ready | out_byte, kind, error_code, last
//
// One input word is taken per cycle while the burst queue has room; decoding is done
// in that cycle and its 0 to 4 results are queued as one burst.
// Results leave one per cycle through the output register while out_ready is high;
// a multi-byte burst therefore holds the output while it drains, and the queue
// (QueueDepth bursts) absorbs that. A result passes the queue entry, the burst register
// cur and the output register. Reset is synchronous; no clearing pass is needed.
// Output stalls fill the queue and then drop in_ready.
module json_string_unescape_utf8 #(
  parameter int unsigned QueueDepth = jsu_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       restart,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] kind,
  output logic [3:0] error_code,
  output logic       last
);
  import jsu_pkg::*;

  logic   push, pop, full, empty;
  entry_t push_entry, rd_data;

  jsu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .restart    (restart),
    .full       (full),
    .push       (push),
    .push_entry (push_entry)
  );

  jsu_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (push_entry),
    .full    (full),
    .pop     (pop),
    .rd_data (rd_data),
    .empty   (empty)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (empty),
    .rd_data    (rd_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .kind       (kind),
    .error_code (error_code),
    .last       (last)
  );

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the JSON string body decoder with UTF-8 output.
`timescale 1ns / 100ps

module testbench;
  import jsu_pkg::*;

  localparam int CYCLE_LIMIT   = 50000;
  localparam int RANDOM_WORDS  = 280;
  localparam int HOLD_CYCLES   = 80;
  localparam int DRAIN_CYCLES  = 40;
  localparam int N_DIRECTED    = 28;

  localparam logic [3:0] NO_CODE   = 4'd0;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [7:0] ESC_LETTERS [8] = '{8'h22, 8'h5C, 8'h2F, 8'h62, 8'h66, 8'h6E,
                                            8'h72, 8'h74};

  typedef enum logic [3:0] {PH_TEXT, PH_ESC, PH_HEX, PH_DONE} dec_phase_t;

  typedef struct {
    logic [7:0] data;
    logic [1:0] kind;
    logic [3:0] code;
    logic       last;
  } result_t;

  // One word of stimulus; where typed is set, data/kind/code give its single result.
  typedef struct packed {
    logic [7:0] b;
    logic       r;
    logic       typed;
    logic [7:0] data;
    logic [1:0] kind;
    logic [3:0] code;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       restart;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic [3:0] error_code;
  logic       last;

  // decoder shadow state
  dec_phase_t  dec_phase;
  logic [1:0]  hex_cnt;
  logic [15:0] code_acc;
  logic [9:0]  hi_bits;
  logic        hi_wait;

  result_t   burst[$];
  result_t   decoded_q[$];
  stim_row_t word_plan_q[$];

  int  mismatches;
  int  results_checked;
  int  random_words;
  int  strings_sent;
  int  in_stalls;
  int  cycle_cnt;
  int  hold_left;
  bit  hold_req;
  bit  hold_taken;
  bit  hold_done;
  bit  quiet;
  bit  start_pending;

  stim_row_t dir_rows [N_DIRECTED] = '{
    '{8'h00, 1'b1, 1'b1, 8'h00, KIND_ERR,  ERR_CTRL},
    '{8'h41, 1'b1, 1'b1, 8'h41, KIND_DATA, NO_CODE},
    '{8'hFF, 1'b0, 1'b1, 8'hFF, KIND_DATA, NO_CODE},
    '{8'h0A, 1'b0, 1'b1, 8'h00, KIND_ERR,  ERR_LF},
    '{8'h0D, 1'b1, 1'b1, 8'h00, KIND_ERR,  ERR_CR},
    '{8'h09, 1'b1, 1'b1, 8'h00, KIND_ERR,  ERR_TAB},
    '{8'h20, 1'b0, 1'b0, 8'h00, KIND_DATA, NO_CODE},
    '{8'h22, 1'b1, 1'b1, 8'h00, KIND_END,  NO_CODE},
    '{8'h5C, 1'b1, 1'b0, 8'h00, KIND_DATA, NO_CODE},
    '{8'h22, 1'b0, 1'b1, 8'h22, KIND_DATA, NO_CODE},
    '{8'h5C, 1'b0, 1'b0, 8'h00, KIND_DATA, NO_CODE},
    '{8'h78, 1'b0, 1'b1, 8'h00, KIND_ERR,  ERR_BAD_ESC},
    '{8'h5C, 1'b1, 1'b0, 8'h00, KIND_DATA, NO_CODE},
    '{8'h75, 1'b0, 1'b0, 8'h00, KIND_DATA, NO_CODE},
    '{8'h22, 1'b0, 1'b1, 8'h00, KIND_ERR,  ERR_BAD_HEX},
    '{8'h5C, 1'b1, 1'b0, 8'h00, KIND_DATA, NO_CODE},
    '{8'h75, 1'b0, 1'b0, 8'h00, KIND_DATA, NO_CODE},
    '{8'h30, 1'b0, 1'b0, 8'h00, KIND_DATA, NO_CODE},
    '{8'h30, 1'b0, 1'b0, 8'h00, KIND_DATA, NO_CODE},
    '{8'h30, 1'b0, 1'b0, 8'h00, KIND_DATA, NO_CODE},
    '{8'h30, 1'b0, 1'b1, 8'h00, KIND_DATA, NO_CODE},
    '{8'h5C, 1'b0, 1'b0, 8'h00, KIND_DATA, NO_CODE},
    '{8'h75, 1'b0, 1'b0, 8'h00, KIND_DATA, NO_CODE},
    '{8'h64, 1'b0, 1'b0, 8'h00, KIND_DATA, NO_CODE},
    '{8'h62, 1'b0, 1'b0, 8'h00, KIND_DATA, NO_CODE},
    '{8'h66, 1'b0, 1'b0, 8'h00, KIND_DATA, NO_CODE},
    '{8'h46, 1'b0, 1'b0, 8'h00, KIND_DATA, NO_CODE},
    '{8'h22, 1'b0, 1'b1, 8'h00, KIND_ERR,  ERR_LONE_HIGH}
  };

  json_string_unescape_utf8 i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .restart    (restart),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .kind       (kind),
    .error_code (error_code),
    .last       (last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------- decoder shadow

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
    return -1;
  endfunction

  function automatic int escape_byte(input logic [7:0] c);
    case (c)
      8'h22:   return 8'h22;
      8'h5C:   return 8'h5C;
      8'h2F:   return 8'h2F;
      8'h62:   return 8'h08;
      8'h66:   return 8'h0C;
      8'h6E:   return 8'h0A;
      8'h72:   return 8'h0D;
      8'h74:   return 8'h09;
      default: return -1;
    endcase
  endfunction

  task automatic emit(input logic [7:0] data, input logic [1:0] k, input logic [3:0] code);
    result_t r;
    r.data = data;
    r.kind = k;
    r.code = code;
    r.last = 1'b0;
    burst.push_back(r);
  endtask

  task automatic fail_with(input logic [3:0] code);
    emit(8'h00, KIND_ERR, code);
    dec_phase = PH_DONE;
  endtask

  task automatic clear_decoder();
    dec_phase = PH_TEXT;
    hex_cnt   = '0;
    code_acc  = '0;
    hi_bits   = '0;
    hi_wait   = 1'b0;
  endtask

  task automatic close_code();
    logic [15:0] cp;
    logic [20:0] full;
    cp = code_acc;
    if (!hi_wait) begin
      if (cp >= 16'hD800 && cp <= 16'hDBFF) begin
        hi_bits = cp[9:0];
        hi_wait = 1'b1;
      end else if (cp >= 16'hDC00 && cp <= 16'hDFFF) begin
        fail_with(ERR_LONE_LOW);
      end else if (cp <= 16'h007F) begin
        emit(cp[7:0], KIND_DATA, NO_CODE);
      end else if (cp <= 16'h07FF) begin
        emit({3'b110, cp[10:6]}, KIND_DATA, NO_CODE);
        emit({2'b10, cp[5:0]}, KIND_DATA, NO_CODE);
      end else begin
        emit({4'b1110, cp[15:12]}, KIND_DATA, NO_CODE);
        emit({2'b10, cp[11:6]}, KIND_DATA, NO_CODE);
        emit({2'b10, cp[5:0]}, KIND_DATA, NO_CODE);
      end
    end else if (cp < 16'hDC00 || cp > 16'hDFFF) begin
      fail_with(ERR_BAD_PAIR);
    end else begin
      full = 21'h10000 + {1'b0, hi_bits, cp[9:0]};
      emit({5'b11110, full[20:18]}, KIND_DATA, NO_CODE);
      emit({2'b10, full[17:12]}, KIND_DATA, NO_CODE);
      emit({2'b10, full[11:6]}, KIND_DATA, NO_CODE);
      emit({2'b10, full[5:0]}, KIND_DATA, NO_CODE);
      hi_wait = 1'b0;
      hi_bits = '0;
    end
  endtask

  // Decode one word into burst, the results it causes in order.
  task automatic decode_word(input logic [7:0] b, input logic fresh);
    int d;
    int e;
    burst.delete();
    if (fresh) clear_decoder();
    if (dec_phase == PH_DONE) return;
    if (b < 8'h20) begin
      case (b)
        8'h0A:   fail_with(ERR_LF);
        8'h0D:   fail_with(ERR_CR);
        8'h09:   fail_with(ERR_TAB);
        default: fail_with(ERR_CTRL);
      endcase
    end else if (dec_phase == PH_TEXT) begin
      if (b == CH_QUOTE) begin
        if (hi_wait) fail_with(ERR_LONE_HIGH);
        else begin
          emit(8'h00, KIND_END, NO_CODE);
          dec_phase = PH_DONE;
        end
      end else if (b == CH_BSLASH) begin
        dec_phase = PH_ESC;
      end else if (hi_wait) begin
        fail_with(ERR_LONE_HIGH);
      end else begin
        emit(b, KIND_DATA, NO_CODE);
      end
    end else if (dec_phase == PH_ESC) begin
      e = escape_byte(b);
      if (b == CH_U) begin
        dec_phase = PH_HEX;
        hex_cnt   = '0;
        code_acc  = '0;
      end else if (e < 0) begin
        fail_with(ERR_BAD_ESC);
      end else if (hi_wait) begin
        fail_with(ERR_LONE_HIGH);
      end else begin
        dec_phase = PH_TEXT;
        emit(e[7:0], KIND_DATA, NO_CODE);
      end
    end else begin
      d = hex_digit(b);
      if (d < 0) begin
        fail_with(ERR_BAD_HEX);
      end else begin
        code_acc = {code_acc[11:0], d[3:0]};
        if (hex_cnt < 2'd3) begin
          hex_cnt++;
        end else begin
          hex_cnt   = '0;
          dec_phase = PH_TEXT;
          close_code();
        end
      end
    end
    if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h (result %0d)",
             $time, what, got, want, results_checked);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    result_t   want;
    stim_row_t plan;
    if (!rst) begin
      if (in_valid && !in_ready) in_stalls++;
      // compare first: a word taken at this edge cannot have a result out yet
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          report_mismatch("unexpected result, kind", kind, 0);
        end else begin
          want = decoded_q.pop_front();
          if (out_byte !== want.data) report_mismatch("out_byte", out_byte, want.data);
          if (kind !== want.kind) report_mismatch("kind", kind, want.kind);
          if (error_code !== want.code) report_mismatch("error_code", error_code, want.code);
          if (last !== want.last) report_mismatch("last", last, want.last);
        end
        results_checked++;
      end
      if (in_valid && in_ready) begin
        plan = word_plan_q.pop_front();
        decode_word(in_byte, restart);
        if (plan.typed) begin
          want.data = plan.data;
          want.kind = plan.kind;
          want.code = plan.code;
          want.last = 1'b1;
          decoded_q.push_back(want);
        end else begin
          foreach (burst[i]) decoded_q.push_back(burst[i]);
        end
      end
    end
  end

  // ---------------------------------------------------------------- driving

  // Offer one word; return at the falling edge after it is taken.
  task automatic send_word(input logic [7:0] b, input logic r, input stim_row_t plan);
    word_plan_q.push_back(plan);
    while (!quiet && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    restart  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic put_word(input logic [7:0] b);
    stim_row_t none;
    none = '0;
    send_word(b, start_pending, none);
    start_pending = 1'b0;
    random_words++;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + 8'(nib);
    return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(8'h20, 8'hFF));
    while (c == CH_QUOTE || c == CH_BSLASH);
    return c;
  endfunction

  function automatic logic [7:0] bad_hex_char();
    logic [7:0] c;
    if ($urandom_range(9) < 3) return CH_QUOTE;
    do c = 8'($urandom_range(8'h20, 8'hFF));
    while (hex_digit(c) >= 0);
    return c;
  endfunction

  function automatic logic [7:0] bad_esc_char();
    logic [7:0] c;
    do c = 8'($urandom_range(8'h20, 8'hFF));
    while (escape_byte(c) >= 0 || c == CH_U);
    return c;
  endfunction

  function automatic logic [15:0] bmp_code();
    logic [15:0] v;
    do v = 16'($urandom_range(16'h0800, 16'hFFFF));
    while (v >= 16'hD800 && v <= 16'hDFFF);
    return v;
  endfunction

  task automatic put_hex_digits(input logic [15:0] v, input int n);
    for (int i = 3; i > 3 - n; i--) put_word(hex_char(v[i*4 +: 4]));
  endtask

  task automatic put_unicode(input logic [15:0] v);
    put_word(CH_BSLASH);
    put_word(CH_U);
    put_hex_digits(v, 4);
  endtask

  // One fault ends the string.
  task automatic put_fault(input int t);
    logic [15:0] v;
    if (t < 89) begin
      put_unicode(16'hDC00 | 16'($urandom_range(10'h3FF)));
    end else if (t < 93) begin
      put_unicode(16'hD800 | 16'($urandom_range(10'h3FF)));
      case ($urandom_range(4))
        0: put_word(plain_char());
        1: put_word(CH_QUOTE);
        2: begin
          put_word(CH_BSLASH);
          put_word(ESC_LETTERS[$urandom_range(7)]);
        end
        3: begin
          put_word(CH_BSLASH);
          put_word(bad_esc_char());
        end
        default: begin
          do v = 16'($urandom);
          while (v >= 16'hDC00 && v <= 16'hDFFF);
          put_unicode(v);
        end
      endcase
    end else if (t < 96) begin
      case ($urandom_range(2))
        0: ;
        1: put_word(CH_BSLASH);
        default: begin
          put_word(CH_BSLASH);
          put_word(CH_U);
          put_hex_digits(16'($urandom), $urandom_range(3));
        end
      endcase
      put_word(8'($urandom_range(8'h1F)));
    end else if (t < 98) begin
      put_word(CH_BSLASH);
      put_word(bad_esc_char());
    end else begin
      put_word(CH_BSLASH);
      put_word(CH_U);
      put_hex_digits(16'($urandom), $urandom_range(3));
      put_word(bad_hex_char());
    end
  endtask

  // A string body with random content; most end in a closing quote.
  task automatic gen_string();
    int  n;
    int  t;
    bit  broken;
    bit  ended;
    stim_row_t none;
    none          = '0;
    start_pending = 1'b1;
    broken        = 1'b0;
    n             = $urandom_range(1, 8);
    strings_sent++;
    for (int i = 0; i < n && !broken; i++) begin
      t = $urandom_range(99);
      if (t < 34) begin
        put_word(plain_char());
      end else if (t < 48) begin
        put_word(CH_BSLASH);
        put_word(ESC_LETTERS[$urandom_range(7)]);
      end else if (t < 58) begin
        put_unicode(16'($urandom_range(16'h007F)));
      end else if (t < 66) begin
        put_unicode(16'($urandom_range(16'h0080, 16'h07FF)));
      end else if (t < 74) begin
        put_unicode(bmp_code());
      end else if (t < 86) begin
        put_unicode(16'hD800 | 16'($urandom_range(10'h3FF)));
        put_unicode(16'hDC00 | 16'($urandom_range(10'h3FF)));
      end else begin
        broken = 1'b1;
        put_fault(t);
      end
    end
    ended = broken;
    if (!broken && $urandom_range(9) < 8) begin
      put_word(CH_QUOTE);
      ended = 1'b1;
    end
    // bytes after the end are dropped until the next restart
    if (ended && $urandom_range(3) == 0)
      repeat ($urandom_range(1, 3)) send_word(8'($urandom), 1'b0, none);
  endtask

  // ---------------------------------------------------------------- receiver

  always @(negedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_left  = HOLD_CYCLES;
      hold_taken = 1'b1;
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= quiet || ($urandom_range(99) >= 27);
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Timeout after %0d cycles", CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------- main sequence

  initial begin
    in_valid  = 1'b0;
    in_byte   = 8'h00;
    restart   = 1'b0;
    rst       = 1'b1;
    clear_decoder();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++)
      send_word(dir_rows[i].b, dir_rows[i].r, dir_rows[i]);

    while (random_words < RANDOM_WORDS) begin
      if (!hold_done && random_words >= 80) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      quiet = (random_words >= 150 && random_words < 230);
      gen_string();
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (decoded_q.size() != 0) report_mismatch("results still owed", decoded_q.size(), 0);

    $display("Sent %0d directed words and %0d random strings (%0d words in string bodies)",
             N_DIRECTED, strings_sent, random_words);
    $display("Checked %0d results; input held off for %0d cycles under output back-pressure",
             results_checked, in_stalls);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/jsu_pkg.sv
rtl/jsu_front.sv
rtl/jsu_fifo.sv
rtl/jsu_back.sv
rtl/json_string_unescape_utf8.sv
tb/sv/testbench.sv
